FILE: hw/rtl/circle_circle_intersection_top_macros.svh
// Assertion macros shared by cci_queue.sv and cci_back.sv.
`ifndef CIRCLE_CIRCLE_INTERSECTION_TOP_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CCI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cci check failed");
`define CCI_NEVER(label, clk, rst, expr) \
   `CCI_ASSERT(label, clk, rst, !(expr))
`else
`define CCI_ASSERT(label, clk, rst, prop)
`define CCI_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: hw/rtl/cci_pkg.sv
package cci_pkg;

   localparam int CW     = 32;
   localparam int RW     = 31;
   localparam int EPSW   = 17;
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   localparam logic CSR_EPSILON = 1'b0;

   localparam logic [2:0] CODE_FAR        = 3'd0;
   localparam logic [2:0] CODE_INSIDE     = 3'd1;
   localparam logic [2:0] CODE_COINCIDENT = 3'd2;
   localparam logic [2:0] CODE_TANGENT    = 3'd3;
   localparam logic [2:0] CODE_TWO_POINTS = 3'd4;

   typedef struct packed {
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
      logic [RW-1:0]        r1;
      logic                 r1_ge_r2;
      logic signed [CW:0]   dx;
      logic signed [CW:0]   dy;
      logic [CW-1:0]        s;
      logic [RW-1:0]        du;
      logic [2*CW-1:0]      d2;
      logic                 far;
   } cci_job_type;

   typedef struct packed {
      logic [2:0]           code;
      logic signed [CW-1:0] pax;
      logic signed [CW-1:0] pay;
      logic signed [CW-1:0] pbx;
      logic signed [CW-1:0] pby;
      logic                 sat;
   } cci_result_type;

endpackage

FILE: hw/rtl/cci_front.sv
module cci_front
   import cci_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4,
   localparam int LW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [CW-1:0] first_center_x,
   input  logic signed [CW-1:0] first_center_y,
   input  logic [RW-1:0]        first_radius,
   input  logic signed [CW-1:0] second_center_x,
   input  logic signed [CW-1:0] second_center_y,
   input  logic [RW-1:0]        second_radius,
   input  logic [LW-1:0]        queue_level,
   output logic                 push,
   output cci_job_type          push_job
);

   logic                 v1_ff, v1_in, v2_ff, v2_in;
   logic signed [CW-1:0] x1_ff, x1_in, y1_ff, y1_in;
   logic [RW-1:0]        r1_ff, r1_in, du_ff, du_in;
   logic                 ge_ff, ge_in;
   logic signed [CW:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [CW:0]          ax_ff, ax_in, ay_ff, ay_in;
   logic [CW-1:0]        s_ff, s_in;
   cci_job_type          job_ff, job_in;
   logic [2*CW-1:0]      sqx, sqy;
   logic [2*CW:0]        d2_sum;
   logic [LW:0]          total;
   logic                 accept;

   always_comb begin
      total  = (LW+1)'(queue_level) + (LW+1)'(v1_ff) + (LW+1)'(v2_ff);
      busy   = total >= (LW+1)'(QUEUE_DEPTH);
      accept = start && !busy;
      v1_in  = accept;
      v2_in  = v1_ff;
      push   = v2_ff;
      x1_in  = first_center_x;
      y1_in  = first_center_y;
      r1_in  = first_radius;
      ge_in  = first_radius >= second_radius;
      du_in  = ge_in ? first_radius - second_radius : second_radius - first_radius;
      s_in   = CW'(first_radius) + CW'(second_radius);
      dx_in  = (CW+1)'(second_center_x) - (CW+1)'(first_center_x);
      dy_in  = (CW+1)'(second_center_y) - (CW+1)'(first_center_y);
      ax_in  = dx_in[CW] ? -dx_in : dx_in;
      ay_in  = dy_in[CW] ? -dy_in : dy_in;
      sqx    = ax_ff[CW-1:0] * ax_ff[CW-1:0];
      sqy    = ay_ff[CW-1:0] * ay_ff[CW-1:0];
      d2_sum = (2*CW+1)'(sqx) + (2*CW+1)'(sqy);
      job_in.x1       = x1_ff;
      job_in.y1       = y1_ff;
      job_in.r1       = r1_ff;
      job_in.r1_ge_r2 = ge_ff;
      job_in.dx       = dx_ff;
      job_in.dy       = dy_ff;
      job_in.s        = s_ff;
      job_in.du       = du_ff;
      job_in.d2       = d2_sum[2*CW-1:0];
      job_in.far      = (ax_ff > (CW+1)'(s_ff)) || (ay_ff > (CW+1)'(s_ff)) || d2_sum[2*CW];
      push_job        = job_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff  <= x1_in;
      y1_ff  <= y1_in;
      r1_ff  <= r1_in;
      ge_ff  <= ge_in;
      du_ff  <= du_in;
      s_ff   <= s_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      job_ff <= job_in;
   end

endmodule

FILE: hw/rtl/cci_queue.sv
`include "circle_circle_intersection_top_macros.svh"
module cci_queue
   import cci_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4,
   localparam int LW = $clog2(QUEUE_DEPTH + 1),
   localparam int PW = $clog2(QUEUE_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cci_job_type   push_job,
   input  logic          pop,
   output cci_job_type   head_job,
   output logic          not_empty,
   output logic [LW-1:0] level
);

   cci_job_type   entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [LW-1:0] level_ff, level_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      level_in = level_ff + LW'(push) - LW'(pop);
      head_job  = entry_ff[rd_ff];
      not_empty = level_ff != '0;
      level     = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   `CCI_NEVER(a_no_overflow, clock, reset, push && !pop && level_ff == LW'(QUEUE_DEPTH))
   `CCI_NEVER(a_no_underflow, clock, reset, pop && level_ff == '0)

endmodule

FILE: hw/rtl/cci_back.sv
`include "circle_circle_intersection_top_macros.svh"
module cci_back
   import cci_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [EPSW-1:0] epsilon,
   input  logic            job_ready,
   input  cci_job_type     job,
   output logic            pop,
   output logic            result_valid,
   output cci_result_type  result
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_ROOT_D = 4'd1;
   localparam logic [3:0] ST_CLASS  = 4'd2;
   localparam logic [3:0] ST_DU2    = 4'd3;
   localparam logic [3:0] ST_R1DU   = 4'd4;
   localparam logic [3:0] ST_NUM    = 4'd5;
   localparam logic [3:0] ST_DIV_A  = 4'd6;
   localparam logic [3:0] ST_AA     = 4'd7;
   localparam logic [3:0] ST_R1SQ   = 4'd8;
   localparam logic [3:0] ST_HH     = 4'd9;
   localparam logic [3:0] ST_ROOT_H = 4'd10;
   localparam logic [3:0] ST_PROD   = 4'd11;
   localparam logic [3:0] ST_SINIT  = 4'd12;
   localparam logic [3:0] ST_SDIV   = 4'd13;
   localparam logic [3:0] ST_SUM    = 4'd14;

   localparam int SQ_STEPS  = CW;
   localparam int DIV_STEPS = 2 * CW;
   localparam int CNTW      = $clog2(DIV_STEPS);
   localparam int DENW      = CW + 2;
   localparam int MW        = CW + 1;
   localparam int SW        = CW + 2;
   localparam int PW        = CW + 4;

   function automatic logic [CW:0] clip_fn(input logic signed [PW-1:0] v);
      logic [CW:0] r;
      r = {1'b0, v[CW-1:0]};
      if (!v[PW-1] && (|v[PW-2:CW-1])) begin
         r = {1'b1, 1'b0, {(CW-1){1'b1}}};
      end else if (v[PW-1] && !(&v[PW-2:CW-1])) begin
         r = {1'b1, 1'b1, {(CW-1){1'b0}}};
      end
      return r;
   endfunction

   logic [3:0]            state_ff, state_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [1:0]            sidx_ff, sidx_in;
   cci_job_type           job_ff, job_in;
   logic [CW-1:0]         dd_ff, dd_in, h_ff, h_in;
   logic [2*CW-1:0]       t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic                  aneg_ff, aneg_in;
   logic [MW-1:0]         am_ff, am_in;
   logic [2*CW-1:0]       sq_v_ff, sq_v_in;
   logic [CW+1:0]         sq_rem_ff, sq_rem_in;
   logic [CW-1:0]         sq_root_ff, sq_root_in;
   logic [2*CW-1:0]       dv_num_ff, dv_num_in;
   logic [DENW-1:0]       dv_rem_ff, dv_rem_in, dv_den_ff, dv_den_in;
   logic signed [SW-1:0]  sc_ff [4];
   logic signed [SW-1:0]  sc_in [4];
   logic                  res_valid_ff, res_valid_in;
   cci_result_type        res_ff, res_in;

   logic [CW+3:0]         sq_rt, sq_trial, sq_diff;
   logic                  sq_ge;
   logic [CW+1:0]         sq_rem_next;
   logic [CW-1:0]         sq_root_next;
   logic [DENW:0]         dv_sh, dv_diff;
   logic                  dv_ge;
   logic [DENW-1:0]       dv_rem_next;
   logic [2*CW-1:0]       dv_num_next;
   logic [MW-1:0]         mul_a, mul_b, adx, ady;
   logic [2*MW-1:0]       mul_p;
   logic [2*CW-1:0]       p_v, q_v, hh;
   logic                  last_sq, last_dv, qneg;
   logic signed [SW-1:0]  qs;
   logic signed [PW-1:0]  bx, by, ox, oy;
   logic [CW:0]           c0, c1, c2, c3;

   always_comb begin
      sq_rt        = {sq_rem_ff, sq_v_ff[2*CW-1 -: 2]};
      sq_trial     = {2'b00, sq_root_ff, 2'b01};
      sq_ge        = sq_rt >= sq_trial;
      sq_diff      = sq_rt - sq_trial;
      sq_rem_next  = sq_ge ? sq_diff[CW+1:0] : sq_rt[CW+1:0];
      sq_root_next = {sq_root_ff[CW-2:0], sq_ge};
      dv_sh        = {dv_rem_ff, dv_num_ff[2*CW-1]};
      dv_ge        = dv_sh >= {1'b0, dv_den_ff};
      dv_diff      = dv_sh - {1'b0, dv_den_ff};
      dv_rem_next  = dv_ge ? dv_diff[DENW-1:0] : dv_sh[DENW-1:0];
      dv_num_next  = {dv_num_ff[2*CW-2:0], dv_ge};
      last_sq      = cnt_ff == CNTW'(SQ_STEPS - 1);
      last_dv      = cnt_ff == CNTW'(DIV_STEPS - 1);
      adx          = job_ff.dx[CW] ? -job_ff.dx : job_ff.dx;
      ady          = job_ff.dy[CW] ? -job_ff.dy : job_ff.dy;

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_CLASS: begin
            mul_a = MW'(dd_ff);
            mul_b = MW'(dd_ff);
         end
         ST_DU2: begin
            mul_a = MW'(job_ff.du);
            mul_b = MW'(job_ff.du);
         end
         ST_R1DU: begin
            mul_a = MW'(job_ff.r1);
            mul_b = MW'(job_ff.du);
         end
         ST_AA: begin
            mul_a = am_ff;
            mul_b = am_ff;
         end
         ST_R1SQ: begin
            mul_a = MW'(job_ff.r1);
            mul_b = MW'(job_ff.r1);
         end
         ST_PROD: begin
            mul_a = sidx_ff[1] ? MW'(h_ff) : am_ff;
            mul_b = (sidx_ff == 2'd0 || sidx_ff == 2'd3) ? adx : ady;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;

      p_v = t0_ff - t1_ff;
      q_v = {t2_ff[2*CW-2:0], 1'b0};
      hh  = (t1_ff >= t0_ff) ? t1_ff - t0_ff : '0;

      case (sidx_ff)
         2'd0:    qneg = aneg_ff ^ job_ff.dx[CW];
         2'd1:    qneg = aneg_ff ^ job_ff.dy[CW];
         2'd2:    qneg = job_ff.dy[CW];
         default: qneg = job_ff.dx[CW];
      endcase
      qs = signed'({1'b0, dv_num_next[MW-1:0]});

      bx = PW'(job_ff.x1) + PW'(sc_ff[0]);
      by = PW'(job_ff.y1) + PW'(sc_ff[1]);
      ox = PW'(sc_ff[2]);
      oy = PW'(sc_ff[3]);
      c0 = clip_fn(bx + ox);
      c1 = clip_fn(by - oy);
      c2 = clip_fn(bx - ox);
      c3 = clip_fn(by + oy);

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sidx_in      = sidx_ff;
      job_in       = job_ff;
      dd_in        = dd_ff;
      h_in         = h_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      aneg_in      = aneg_ff;
      am_in        = am_ff;
      sq_v_in      = sq_v_ff;
      sq_rem_in    = sq_rem_ff;
      sq_root_in   = sq_root_ff;
      dv_num_in    = dv_num_ff;
      dv_rem_in    = dv_rem_ff;
      dv_den_in    = dv_den_ff;
      sc_in        = sc_ff;
      res_valid_in = 1'b0;
      res_in       = res_ff;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               pop        = 1'b1;
               job_in     = job;
               sq_v_in    = job.d2;
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = '0;
               state_in   = job.far ? ST_CLASS : ST_ROOT_D;
            end
         end
         ST_ROOT_D: begin
            sq_v_in    = {sq_v_ff[2*CW-3:0], 2'b00};
            sq_rem_in  = sq_rem_next;
            sq_root_in = sq_root_next;
            cnt_in     = cnt_ff + 1'b1;
            if (last_sq) begin
               dd_in    = sq_root_next;
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            t0_in      = mul_p[2*CW-1:0];
            res_in.pax = '0;
            res_in.pay = '0;
            res_in.pbx = '0;
            res_in.pby = '0;
            res_in.sat = 1'b0;
            state_in   = ST_IDLE;
            if (job_ff.far || dd_ff > job_ff.s) begin
               res_in.code  = CODE_FAR;
               res_valid_in = 1'b1;
            end else if (dd_ff < CW'(job_ff.du)) begin
               res_in.code  = CODE_INSIDE;
               res_valid_in = 1'b1;
            end else if ((dd_ff < CW'(epsilon) && CW'(job_ff.du) < CW'(epsilon))
                         || dd_ff == '0) begin
               res_in.code  = CODE_COINCIDENT;
               res_valid_in = 1'b1;
            end else begin
               state_in = ST_DU2;
            end
         end
         ST_DU2: begin
            t1_in    = mul_p[2*CW-1:0];
            state_in = ST_R1DU;
         end
         ST_R1DU: begin
            t2_in    = mul_p[2*CW-1:0];
            state_in = ST_NUM;
         end
         ST_NUM: begin
            aneg_in = 1'b0;
            if (job_ff.r1_ge_r2) begin
               dv_num_in = p_v + q_v + (2*CW)'(dd_ff);
            end else if (p_v >= q_v) begin
               dv_num_in = p_v - q_v + (2*CW)'(dd_ff);
            end else begin
               dv_num_in = q_v - p_v + (2*CW)'(dd_ff);
               aneg_in   = 1'b1;
            end
            dv_rem_in = '0;
            dv_den_in = {1'b0, dd_ff, 1'b0};
            cnt_in    = '0;
            state_in  = ST_DIV_A;
         end
         ST_DIV_A: begin
            dv_num_in = dv_num_next;
            dv_rem_in = dv_rem_next;
            cnt_in    = cnt_ff + 1'b1;
            if (last_dv) begin
               am_in    = dv_num_next[MW-1:0];
               state_in = ST_AA;
            end
         end
         ST_AA: begin
            t0_in    = mul_p[2*CW-1:0];
            state_in = ST_R1SQ;
         end
         ST_R1SQ: begin
            t1_in    = mul_p[2*CW-1:0];
            state_in = ST_HH;
         end
         ST_HH: begin
            sq_v_in    = hh;
            sq_rem_in  = '0;
            sq_root_in = '0;
            cnt_in     = '0;
            state_in   = ST_ROOT_H;
         end
         ST_ROOT_H: begin
            sq_v_in    = {sq_v_ff[2*CW-3:0], 2'b00};
            sq_rem_in  = sq_rem_next;
            sq_root_in = sq_root_next;
            cnt_in     = cnt_ff + 1'b1;
            if (last_sq) begin
               h_in     = sq_root_next;
               sidx_in  = '0;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            t0_in    = mul_p[2*CW-1:0];
            state_in = ST_SINIT;
         end
         ST_SINIT: begin
            dv_num_in = t0_ff + (2*CW)'(dd_ff >> 1);
            dv_rem_in = '0;
            dv_den_in = DENW'(dd_ff);
            cnt_in    = '0;
            state_in  = ST_SDIV;
         end
         ST_SDIV: begin
            dv_num_in = dv_num_next;
            dv_rem_in = dv_rem_next;
            cnt_in    = cnt_ff + 1'b1;
            if (last_dv) begin
               sc_in[sidx_ff] = qneg ? -qs : qs;
               sidx_in        = sidx_ff + 1'b1;
               state_in       = (sidx_ff == 2'd3) ? ST_SUM : ST_PROD;
            end
         end
         ST_SUM: begin
            res_in.pax   = c0[CW-1:0];
            res_in.pay   = c1[CW-1:0];
            res_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if ((job_ff.s - dd_ff) < CW'(epsilon)) begin
               res_in.code = CODE_TANGENT;
               res_in.pbx  = '0;
               res_in.pby  = '0;
               res_in.sat  = c0[CW] | c1[CW];
            end else begin
               res_in.code = CODE_TWO_POINTS;
               res_in.pbx  = c2[CW-1:0];
               res_in.pby  = c3[CW-1:0];
               res_in.sat  = c0[CW] | c1[CW] | c2[CW] | c3[CW];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result_valid = res_valid_ff;
      result       = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      sidx_ff    <= sidx_in;
      job_ff     <= job_in;
      dd_ff      <= dd_in;
      h_ff       <= h_in;
      t0_ff      <= t0_in;
      t1_ff      <= t1_in;
      t2_ff      <= t2_in;
      aneg_ff    <= aneg_in;
      am_ff      <= am_in;
      sq_v_ff    <= sq_v_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      dv_num_ff  <= dv_num_in;
      dv_rem_ff  <= dv_rem_in;
      dv_den_ff  <= dv_den_in;
      sc_ff      <= sc_in;
      res_ff     <= res_in;
   end

   `CCI_ASSERT(a_single_strobe, clock, reset, result_valid |=> !result_valid)
   `CCI_ASSERT(a_strobe_source, clock, reset, result_valid |-> $past(state_ff == ST_CLASS || state_ff == ST_SUM))
   `CCI_ASSERT(a_early_zero, clock, reset, result_valid && (result.code == CODE_FAR || result.code == CODE_INSIDE || result.code == CODE_COINCIDENT) |-> (result.pax == '0 && result.pay == '0 && result.pbx == '0 && result.pby == '0 && !result.sat))

endmodule

FILE: hw/rtl/circle_circle_intersection_top.sv
// An accepted request passes through the front stages, the queue and the back-end sequencer;
// it waits in the queue while the sequencer still works on an earlier request.
// The sequencer skips the distance root for pairs that the front stages already find too far apart
// and ends after classification in the other too-far, contained and coincident cases.
// That sequencer, with its shared multiplier, divider and root unit, sets the throughput;
// a four-entry queue lets the front keep accepting while it works. Results cannot be stalled.
// Synchronous active-high reset empties the pipeline and sets epsilon to 0.001 in fixed point.
module circle_circle_intersection_top
   import cci_pkg::*;
#(
   parameter int FRAC_BITS   = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [CW-1:0] req_first_center_x,
   input  logic signed [CW-1:0] req_first_center_y,
   input  logic [RW-1:0]        req_first_radius,
   input  logic signed [CW-1:0] req_second_center_x,
   input  logic signed [CW-1:0] req_second_center_y,
   input  logic [RW-1:0]        req_second_radius,
   output logic                 rsp_strobe,
   output logic [2:0]           rsp_case_code,
   output logic signed [CW-1:0] rsp_point_a_x,
   output logic signed [CW-1:0] rsp_point_a_y,
   output logic signed [CW-1:0] rsp_point_b_x,
   output logic signed [CW-1:0] rsp_point_b_y,
   output logic                 rsp_saturated,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [CSR_AW-1:0]    paddr,
   input  logic [CSR_DW-1:0]    pwdata,
   output logic [CSR_DW-1:0]    prdata,
   output logic                 pready
);

   localparam int LW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [EPSW-1:0] EPS_RESET = EPSW'(((1 << FRAC_BITS) + 500) / 1000);

   logic [EPSW-1:0] eps_ff, eps_in;
   logic            push, pop, not_empty, res_valid;
   cci_job_type     push_job, head_job;
   logic [LW-1:0]   level;
   cci_result_type  res;

   always_comb begin
      pready = 1'b1;
      eps_in = eps_ff;
      if (psel && penable && pwrite && pready && paddr[2] == CSR_EPSILON) begin
         eps_in = pwdata[EPSW-1:0];
      end
      prdata = (paddr[2] == CSR_EPSILON) ? CSR_DW'(eps_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else begin
         eps_ff <= eps_in;
      end
   end

   cci_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .first_center_x  (req_first_center_x),
      .first_center_y  (req_first_center_y),
      .first_radius    (req_first_radius),
      .second_center_x (req_second_center_x),
      .second_center_y (req_second_center_y),
      .second_radius   (req_second_radius),
      .queue_level     (level),
      .push            (push),
      .push_job        (push_job)
   );

   cci_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty),
      .level     (level)
   );

   cci_back u_back (
      .clock        (clock),
      .reset        (reset),
      .epsilon      (eps_ff),
      .job_ready    (not_empty),
      .job          (head_job),
      .pop          (pop),
      .result_valid (res_valid),
      .result       (res)
   );

   assign rsp_strobe    = res_valid;
   assign rsp_case_code = res.code;
   assign rsp_point_a_x = res.pax;
   assign rsp_point_a_y = res.pay;
   assign rsp_point_b_x = res.pbx;
   assign rsp_point_b_y = res.pby;
   assign rsp_saturated = res.sat;

endmodule
